FILE: src/liap_pkg.sv
// shared types and constants of the lifetime interval address planner
package liap_pkg;

  localparam int MAX_ALLOCS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int TIME_W     = 32;
  localparam int ADDR_W     = 38;

  // sorter cell operations
  localparam logic [1:0] SOP_HOLD  = 2'd0;
  localparam logic [1:0] SOP_LOAD  = 2'd1;
  localparam logic [1:0] SOP_DRAIN = 2'd2;

  // bucket cell operations
  localparam logic [1:0] BOP_HOLD  = 2'd0;
  localparam logic [1:0] BOP_PLACE = 2'd1;
  localparam logic [1:0] BOP_SHIFT = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] size_bytes;
    logic [IDX_W-1:0]  idx;
  } rec_t;

  typedef struct packed {
    logic [TIME_W-1:0] end_time;
    logic [IDX_W-1:0]  id;
    logic [TIME_W-1:0] widest;
  } bkt_t;

  typedef struct packed {
    logic [1:0] op;
    rec_t       rec;
  } sort_ctl_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              found;
    logic              pull_down;
    logic [TIME_W-1:0] start_time;
    bkt_t              nb;
  } bkt_ctl_t;

endpackage

FILE: src/lifetime_interval_address_planner_top.sv
// Lifetime interval address planner: records are taken one per cycle while loading
// and kept sorted (end time up, size down, load order) in a chain of 64 sorter
// cells. The beat flagged final_record starts planning: the sorted records drain
// into a chain of 64 bucket cells at one per cycle, the buckets then shift out one
// per cycle to lay out addresses, and each result is then read from the memories
// in the read-record and read-bucket states before it is offered. No input is
// taken until the last result has gone.
module lifetime_interval_address_planner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_start_time,
  input  logic [31:0] in_end_time,
  input  logic [31:0] in_size_bytes,
  input  logic        in_final_record,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_record_index,
  output logic [37:0] out_placed_address,
  output logic [5:0]  out_bucket_number,
  output logic [37:0] out_footprint,
  output logic        out_dropped_flag,
  output logic        out_end_of_run
);

  localparam int N = liap_pkg::MAX_ALLOCS;
  localparam int CW = liap_pkg::CNT_W;
  localparam int IW = liap_pkg::IDX_W;
  localparam int AW = liap_pkg::ADDR_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PLACE  = 3'd1;
  localparam logic [2:0] ST_LAYOUT = 3'd2;
  localparam logic [2:0] ST_RD_REC = 3'd3;
  localparam logic [2:0] ST_RD_BKT = 3'd4;
  localparam logic [2:0] ST_SHOW   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] rcnt_r, rcnt_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          ovf_r, ovf_nxt;

  logic in_acc, out_acc, has_room, last_k;

  liap_pkg::sort_ctl_t sctl;
  liap_pkg::bkt_ctl_t  bctl;
  liap_pkg::rec_t      sq  [0:N+1];
  logic [N+1:0]        bef_x;
  liap_pkg::bkt_t      bq  [0:N+1];
  logic [N+1:0]        le_x, ge_x;
  logic [N-1:0]        fone;
  liap_pkg::bkt_t      fsel;
  liap_pkg::rec_t      head;

  // memories: sorted record list and bucket layout by bucket id
  logic [2*IW-1:0] rec_mem  [0:N-1];
  logic [IW-1:0]   pos_mem  [0:N-1];
  logic [AW-1:0]   addr_mem [0:N-1];
  logic [2*IW-1:0] recq_r;
  logic [IW-1:0]   posq_r;
  logic [AW-1:0]   addrq_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (state_r == ST_SHOW);
  assign out_acc  = out_valid && out_ready;
  assign has_room = (rcnt_r < CW'(N));
  assign last_k   = (k_r == n_r - CW'(1));
  assign head     = sq[1];

  // sorter chain
  always_comb begin
    sctl.op = liap_pkg::SOP_HOLD;
    if (in_acc && has_room) sctl.op = liap_pkg::SOP_LOAD;
    else if (state_r == ST_PLACE) sctl.op = liap_pkg::SOP_DRAIN;
    sctl.rec.start_time = in_start_time;
    sctl.rec.end_time   = in_end_time;
    sctl.rec.size_bytes = in_size_bytes;
    sctl.rec.idx        = rcnt_r[IW-1:0];
  end

  assign sq[0]      = '0;
  assign sq[N+1]    = '0;
  assign bef_x[0]   = 1'b0;
  assign bef_x[N+1] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_srt
    liap_sort_cell u_cell (
      .clk        (clk),
      .ctl        (sctl),
      .valid_i    (rcnt_r > CW'(i)),
      .left_before(bef_x[i]),
      .left_q     (sq[i]),
      .right_q    (sq[i+2]),
      .q          (sq[i+1]),
      .ahead      (bef_x[i+1])
    );
  end

  // bucket chain
  assign bq[0]      = '0;
  assign bq[N+1]    = '0;
  assign ge_x[0]    = 1'b0;
  assign ge_x[N+1]  = 1'b1;
  assign le_x[0]    = 1'b0;
  assign le_x[N+1]  = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_bkt
    liap_bkt_cell u_cell (
      .clk     (clk),
      .ctl     (bctl),
      .valid_i (bcnt_r > CW'(i)),
      .ge_left (ge_x[i]),
      .ge_right(ge_x[i+2]),
      .le_right(le_x[i+2]),
      .left_q  (bq[i]),
      .right_q (bq[i+2]),
      .q       (bq[i+1]),
      .le      (le_x[i+1]),
      .ge      (ge_x[i+1])
    );
    assign fone[i] = le_x[i+1] && !le_x[i+2];
  end

  // pick the last bucket that is free by the record's start
  always_comb begin
    fsel = '0;
    for (int i = 0; i < N; i++) begin
      if (fone[i]) fsel = fsel | bq[i+1];
    end
  end

  // placement control and updated bucket
  always_comb begin
    bctl.op = liap_pkg::BOP_HOLD;
    if (state_r == ST_PLACE) bctl.op = liap_pkg::BOP_PLACE;
    else if (state_r == ST_LAYOUT) bctl.op = liap_pkg::BOP_SHIFT;
    bctl.found       = le_x[1];
    bctl.pull_down   = |(fone & ~ge_x[N:1]);
    bctl.start_time  = head.start_time;
    bctl.nb.end_time = head.end_time;
    if (le_x[1]) begin
      bctl.nb.id     = fsel.id;
      bctl.nb.widest = (head.size_bytes > fsel.widest) ? head.size_bytes : fsel.widest;
    end else begin
      bctl.nb.id     = bcnt_r[IW-1:0];
      bctl.nb.widest = head.size_bytes;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rcnt_nxt  = rcnt_r;
    bcnt_nxt  = bcnt_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    addr_nxt  = addr_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_room) rcnt_nxt = rcnt_r + CW'(1);
          else          ovf_nxt  = 1'b1;
          if (in_final_record) begin
            n_nxt     = has_room ? rcnt_r + CW'(1) : rcnt_r;
            k_nxt     = '0;
            bcnt_nxt  = '0;
            state_nxt = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        if (!le_x[1]) bcnt_nxt = bcnt_r + CW'(1);
        k_nxt = k_r + CW'(1);
        if (last_k) begin
          j_nxt     = '0;
          addr_nxt  = '0;
          state_nxt = ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        j_nxt    = j_r + CW'(1);
        addr_nxt = addr_r + AW'(bq[1].widest);
        if (j_r == bcnt_r - CW'(1)) begin
          k_nxt     = '0;
          state_nxt = ST_RD_REC;
        end
      end
      ST_RD_REC: state_nxt = ST_RD_BKT;
      ST_RD_BKT: state_nxt = ST_SHOW;
      ST_SHOW: begin
        if (out_acc) begin
          if (last_k) begin
            rcnt_nxt  = '0;
            bcnt_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_RD_REC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rcnt_r  <= '0;
      bcnt_r  <= '0;
      n_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      addr_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rcnt_r  <= rcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      addr_r  <= addr_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // sorted list memory
  always_ff @(posedge clk) begin
    if (state_r == ST_PLACE) rec_mem[k_r[IW-1:0]] <= {head.idx, bctl.nb.id};
    if (state_r == ST_RD_REC) recq_r <= rec_mem[k_r[IW-1:0]];
  end

  // bucket layout memories
  always_ff @(posedge clk) begin
    if (state_r == ST_LAYOUT) begin
      pos_mem[bq[1].id]  <= j_r[IW-1:0];
      addr_mem[bq[1].id] <= addr_r;
    end
    if (state_r == ST_RD_BKT) begin
      posq_r  <= pos_mem[recq_r[IW-1:0]];
      addrq_r <= addr_mem[recq_r[IW-1:0]];
    end
  end

  // result beat
  assign out_record_index   = recq_r[2*IW-1:IW];
  assign out_placed_address = addrq_r;
  assign out_bucket_number  = posq_r;
  assign out_footprint      = addr_r;
  assign out_dropped_flag   = ovf_r;
  assign out_end_of_run     = last_k;

  a_buckets_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE) |-> (bcnt_r <= k_r))
    else $error("more buckets than placed records");

  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (k_r < n_r))
    else $error("result beyond stored records");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CW'(N))
    else $error("record count past capacity");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && last_k) |=> (rcnt_r == '0 && !ovf_r))
    else $error("run state not cleared");

endmodule

FILE: src/liap_sort_cell.sv
// one cell of the sorted record chain
module liap_sort_cell (
  input  logic               clk,
  input  liap_pkg::sort_ctl_t ctl,
  input  logic               valid_i,
  input  logic               left_before,
  input  liap_pkg::rec_t     left_q,
  input  liap_pkg::rec_t     right_q,
  output liap_pkg::rec_t     q,
  output logic               ahead
);

  liap_pkg::rec_t q_r;

  // new record sorts ahead of the held one (empty cell always)
  always_comb begin
    ahead = !valid_i
          || (ctl.rec.end_time < q_r.end_time)
          || ((ctl.rec.end_time == q_r.end_time) && (ctl.rec.size_bytes > q_r.size_bytes));
  end

  // insert, shift right on insert, shift left on drain
  always_ff @(posedge clk) begin
    case (ctl.op)
      liap_pkg::SOP_LOAD: begin
        if (ahead && !left_before) q_r <= ctl.rec;
        else if (left_before)      q_r <= left_q;
      end
      liap_pkg::SOP_DRAIN: q_r <= right_q;
      default: q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule

FILE: src/liap_bkt_cell.sv
// one cell of the bucket chain, kept in end-time order
module liap_bkt_cell (
  input  logic               clk,
  input  liap_pkg::bkt_ctl_t ctl,
  input  logic               valid_i,
  input  logic               ge_left,
  input  logic               ge_right,
  input  logic               le_right,
  input  liap_pkg::bkt_t     left_q,
  input  liap_pkg::bkt_t     right_q,
  output liap_pkg::bkt_t     q,
  output logic               le,
  output logic               ge
);

  liap_pkg::bkt_t q_r;

  // fits before the record starts / ends no earlier than the record
  always_comb begin
    le = valid_i && (q_r.end_time <= ctl.start_time);
    ge = !valid_i || (q_r.end_time >= ctl.nb.end_time);
  end

  // remove the chosen bucket and insert the updated one (or insert a new one if none fits); shift on layout
  always_ff @(posedge clk) begin
    case (ctl.op)
      liap_pkg::BOP_PLACE: begin
        if (!ctl.found) begin
          if (ge && !ge_left) q_r <= ctl.nb;
          else if (ge_left)   q_r <= left_q;
        end else if (ctl.pull_down) begin
          if (!ge && ge_right)                q_r <= ctl.nb;
          else if (!le_right && !ge_right)    q_r <= right_q;
        end else begin
          if (ge && !ge_left)     q_r <= ctl.nb;
          else if (ge_left && le) q_r <= left_q;
        end
      end
      liap_pkg::BOP_SHIFT: q_r <= right_q;
      default: q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule
